// File: hw/rtl/hsd_pkg.sv
// Shared types and constants for the Huffman stream decoder.
`default_nettype none

package hsd_pkg;

  localparam int unsigned SymW            = 8;
  localparam int unsigned CountW          = 32;
  localparam int unsigned CountBytes      = 4;
  localparam int unsigned HdrW            = 2;
  localparam int unsigned AlphabetSizeDef = 256;

  localparam logic [SymW-1:0] FlagPass  = 8'd1;
  localparam logic [SymW-1:0] FlagCoded = 8'd0;

  typedef enum logic [2:0] {
    PH_FLAG  = 3'd0,
    PH_PASS  = 3'd1,
    PH_COUNT = 3'd2,
    PH_TREE  = 3'd3,
    PH_LEAF  = 3'd4,
    PH_CODE  = 3'd5,
    PH_DONE  = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_BITS  = 2'd1,
    ST_POP   = 2'd2,
    ST_FLUSH = 2'd3
  } ctl_e;

  typedef struct packed {
    logic [SymW-1:0]   symbol;
    logic [CountW-1:0] rep;
    logic              done;
  } emit_t;

  typedef struct packed {
    logic  push;
    logic  flush;
    emit_t item;
  } os_ctl_t;

  typedef struct packed {
    logic push_ok;
    logic flush_ok;
    logic hold_v;
  } os_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/hsd_if.sv
// Valid/ready channel interfaces for the decoder input and result items.
`default_nettype none

interface hsd_in_if;
  logic                     valid;
  logic                     ready;
  logic [hsd_pkg::SymW-1:0] in_byte;
  logic                     stream_start;

  modport source (output valid, output in_byte, output stream_start, input ready);
  modport sink   (input valid, input in_byte, input stream_start, output ready);
endinterface

interface hsd_out_if;
  logic                       valid;
  logic                       ready;
  logic [hsd_pkg::SymW-1:0]   out_symbol;
  logic [hsd_pkg::CountW-1:0] repeat_res;
  logic                       last_of_item;
  logic                       stream_done;

  modport source (output valid, output out_symbol, output repeat_res,
                  output last_of_item, output stream_done, input ready);
  modport sink   (input valid, input out_symbol, input repeat_res,
                  input last_of_item, input stream_done, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/huffman_stream_decoder.sv
// Huffman stream decoder top level: header parse, tree build, code walk.
// Flag, count and ignored bytes are taken without leaving idle; a pass-through byte
// enters the hold register, then flushes. Tree/code bytes: accept, then the bits one
// by one (at most one node-memory access each), a code read in flight, pops, flush.
// Throughput is one byte at a time: input is ready only while the sequencer is idle.
// Reset (async, rst_ni low) returns to waiting for a flag byte; memories keep data.
`default_nettype none

module huffman_stream_decoder #(
  parameter int unsigned ALPHABET_SIZE = hsd_pkg::AlphabetSizeDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hsd_in_if.sink    in_i,
  hsd_out_if.source out_o
);

  // Node layout: leaf flag, symbol, left child, right child.
  localparam int unsigned NodeCap  = 2 * ALPHABET_SIZE - 1;
  localparam int unsigned NAW      = $clog2(NodeCap);
  localparam int unsigned NodeW    = 1 + hsd_pkg::SymW + 2 * NAW;
  localparam int unsigned SAW      = $clog2(ALPHABET_SIZE);
  localparam int unsigned StkTopW  = $clog2(ALPHABET_SIZE + 1);
  localparam int unsigned SymW     = hsd_pkg::SymW;
  localparam int unsigned CountW   = hsd_pkg::CountW;
  localparam int unsigned HdrW     = hsd_pkg::HdrW;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  hsd_pkg::ctl_e      st_q, st_d;
  hsd_pkg::phase_e    phase_q, phase_d;
  logic [HdrW-1:0]    hdr_q, hdr_d;
  logic [CountW-1:0]  rem_q, rem_d;
  logic [SymW-1:0]    leaf_q, leaf_d;
  logic [2:0]         lcnt_q, lcnt_d;
  logic [StkTopW-1:0] stk_top_q, stk_top_d;
  logic [NAW-1:0]     next_free_q, next_free_d;
  logic [NAW-1:0]     walk_q, walk_d;
  logic [NodeW-1:0]   root_q, root_d;   // copy of node 0, saves a read per symbol
  logic [NodeW-1:0]   cur_q, cur_d;     // content of the node the walk sits on
  logic [SymW-1:0]    byte_q, byte_d;
  logic [3:0]         bits_left_q, bits_left_d;
  logic               rd_pend_q, rd_pend_d;  // node read issued, result due now

  // Memories: node store and pending-right stack, both with registered (sync) read.
  logic [NodeW-1:0] node_mem [NodeCap];
  logic [NAW-1:0]   stk_mem  [ALPHABET_SIZE];
  logic             node_we, node_re;
  logic [NAW-1:0]   node_wa, node_ra;
  logic [NodeW-1:0] node_wd;
  logic [NodeW-1:0] node_rd_q;
  logic             stk_we, stk_re;
  logic [SAW-1:0]   stk_wa, stk_ra;
  logic [NAW-1:0]   stk_wd;
  logic [NAW-1:0]   stk_rd_q;

  hsd_pkg::os_ctl_t  os_ctl;
  hsd_pkg::os_stat_t os_stat;

  // ---------------------------------------------------------------------------
  // Datapath helpers
  // ---------------------------------------------------------------------------
  logic               accept;
  logic               adv;
  logic               cur_bit;
  logic [2:0]         bit_idx;
  logic [NAW:0]       alloc_end;
  logic               overflow;
  logic [SymW-1:0]    leaf_nxt;
  logic [CountW-1:0]  rem_dec;
  logic [NodeW-1:0]   next_c;
  logic [StkTopW-1:0] stk_pop;
  hsd_pkg::phase_e    ph_in;

  function automatic logic [NAW-1:0] child(input logic [NodeW-1:0] node, input logic b);
    child = b ? node[NAW-1:0] : node[2*NAW-1:NAW];
  endfunction

  assign in_i.ready = (st_q == hsd_pkg::ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  assign bit_idx   = 3'(bits_left_q - 4'd1);
  assign cur_bit   = byte_q[bit_idx];
  assign alloc_end = {1'b0, next_free_q} + (NAW + 1)'(2);
  assign overflow  = (alloc_end > (NAW + 1)'(NodeCap)) ||
                     (stk_top_q >= StkTopW'(ALPHABET_SIZE));
  assign leaf_nxt  = {leaf_q[SymW-2:0], cur_bit};
  assign rem_dec   = rem_q - CountW'(1);
  assign stk_pop   = stk_top_q - StkTopW'(1);
  assign ph_in     = in_i.stream_start ? hsd_pkg::PH_FLAG : phase_q;

  // A result that cannot enter the hold register freezes the whole cycle.
  assign adv = !(os_ctl.push && !os_stat.push_ok);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    st_d        = st_q;
    phase_d     = phase_q;
    hdr_d       = hdr_q;
    rem_d       = rem_q;
    leaf_d      = leaf_q;
    lcnt_d      = lcnt_q;
    stk_top_d   = stk_top_q;
    next_free_d = next_free_q;
    walk_d      = walk_q;
    root_d      = root_q;
    cur_d       = cur_q;
    byte_d      = byte_q;
    bits_left_d = bits_left_q;
    rd_pend_d   = rd_pend_q;
    node_we     = 1'b0;
    node_wa     = walk_q;
    node_wd     = '0;
    node_re     = 1'b0;
    node_ra     = '0;
    stk_we      = 1'b0;
    stk_wa      = stk_top_q[SAW-1:0];
    stk_wd      = next_free_q + NAW'(1);
    stk_re      = 1'b0;
    stk_ra      = stk_pop[SAW-1:0];
    next_c      = node_rd_q;
    os_ctl      = '0;

    unique case (st_q)
      hsd_pkg::ST_IDLE: begin
        if (accept) begin
          phase_d = ph_in;
          unique case (ph_in)
            hsd_pkg::PH_FLAG: begin
              if (in_i.stream_start) begin
                if (in_i.in_byte == hsd_pkg::FlagPass) begin
                  phase_d = hsd_pkg::PH_PASS;
                end else if (in_i.in_byte == hsd_pkg::FlagCoded) begin
                  phase_d = hsd_pkg::PH_COUNT;
                  hdr_d   = '0;
                  rem_d   = '0;
                end else begin
                  phase_d = hsd_pkg::PH_DONE;
                end
              end
            end
            hsd_pkg::PH_PASS: begin
              os_ctl.push        = 1'b1;
              os_ctl.item.symbol = in_i.in_byte;
              os_ctl.item.rep    = CountW'(1);
              os_ctl.item.done   = 1'b0;
              st_d               = hsd_pkg::ST_FLUSH;
            end
            hsd_pkg::PH_COUNT: begin
              rem_d = {rem_q[CountW-SymW-1:0], in_i.in_byte};
              if (hdr_q == HdrW'(hsd_pkg::CountBytes - 1)) begin
                hdr_d = '0;
                if (rem_d == '0) begin
                  phase_d = hsd_pkg::PH_DONE;
                end else begin
                  phase_d     = hsd_pkg::PH_TREE;
                  stk_top_d   = '0;
                  next_free_d = NAW'(1);
                  walk_d      = '0;
                end
              end else begin
                hdr_d = hdr_q + HdrW'(1);
              end
            end
            hsd_pkg::PH_TREE, hsd_pkg::PH_LEAF, hsd_pkg::PH_CODE: begin
              byte_d      = in_i.in_byte;
              bits_left_d = 4'd8;
              st_d        = hsd_pkg::ST_BITS;
            end
            default: begin
              // abandoned or finished stream: byte dropped
            end
          endcase
        end
      end

      hsd_pkg::ST_BITS: begin
        if (rd_pend_q) begin
          // child node arrived: emit on a leaf, then step with the next bit
          if (node_rd_q[NodeW-1]) begin
            os_ctl.push        = 1'b1;
            os_ctl.item.symbol = node_rd_q[NodeW-2 -: SymW];
            os_ctl.item.rep    = CountW'(1);
            os_ctl.item.done   = (rem_dec == '0);
            rem_d              = rem_dec;
            next_c             = root_q;
          end
          if (node_rd_q[NodeW-1] && rem_dec == '0) begin
            phase_d   = hsd_pkg::PH_DONE;
            rd_pend_d = 1'b0;
            st_d      = hsd_pkg::ST_FLUSH;
          end else if (bits_left_q == '0) begin
            cur_d     = next_c;
            rd_pend_d = 1'b0;
            st_d      = hsd_pkg::ST_FLUSH;
          end else begin
            node_re     = 1'b1;
            node_ra     = child(next_c, cur_bit);
            bits_left_d = bits_left_q - 4'd1;
          end
        end else if (bits_left_q == '0) begin
          st_d = hsd_pkg::ST_FLUSH;
        end else begin
          unique case (phase_q)
            hsd_pkg::PH_CODE: begin
              node_re     = 1'b1;
              node_ra     = child(cur_q, cur_bit);
              rd_pend_d   = 1'b1;
              bits_left_d = bits_left_q - 4'd1;
            end
            hsd_pkg::PH_TREE: begin
              bits_left_d = bits_left_q - 4'd1;
              if (cur_bit) begin
                phase_d = hsd_pkg::PH_LEAF;
                leaf_d  = '0;
                lcnt_d  = '0;
              end else if (overflow) begin
                phase_d = hsd_pkg::PH_DONE;
              end else begin
                // internal node: children at next_free and next_free + 1
                node_we     = 1'b1;
                node_wd     = {1'b0, {SymW{1'b0}}, next_free_q, next_free_q + NAW'(1)};
                stk_we      = 1'b1;
                stk_top_d   = stk_top_q + StkTopW'(1);
                next_free_d = alloc_end[NAW-1:0];
                walk_d      = next_free_q;
                if (walk_q == '0) begin
                  root_d = node_wd;
                end
              end
            end
            hsd_pkg::PH_LEAF: begin
              bits_left_d = bits_left_q - 4'd1;
              leaf_d      = leaf_nxt;
              lcnt_d      = lcnt_q + 3'd1;
              if (lcnt_q == 3'd7) begin
                node_we = 1'b1;
                node_wd = {1'b1, leaf_nxt, {(2 * NAW){1'b0}}};
                if (walk_q == '0) begin
                  root_d = node_wd;
                end
                if (stk_top_q == '0) begin
                  if (walk_q == '0) begin
                    // single-leaf tree: one result carries the whole count
                    os_ctl.push        = 1'b1;
                    os_ctl.item.symbol = leaf_nxt;
                    os_ctl.item.rep    = rem_q;
                    os_ctl.item.done   = 1'b1;
                    rem_d              = '0;
                    phase_d            = hsd_pkg::PH_DONE;
                  end else begin
                    walk_d  = '0;
                    cur_d   = root_q;
                    phase_d = hsd_pkg::PH_CODE;
                  end
                end else begin
                  stk_top_d = stk_pop;
                  stk_re    = 1'b1;
                  phase_d   = hsd_pkg::PH_TREE;
                  st_d      = hsd_pkg::ST_POP;
                end
              end
            end
            default: begin
              st_d = hsd_pkg::ST_FLUSH;
            end
          endcase
        end
      end

      hsd_pkg::ST_POP: begin
        walk_d = stk_rd_q;
        st_d   = hsd_pkg::ST_BITS;
      end

      hsd_pkg::ST_FLUSH: begin
        os_ctl.flush = 1'b1;
        if (os_stat.flush_ok) begin
          st_d = hsd_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= hsd_pkg::ST_IDLE;
      phase_q     <= hsd_pkg::PH_FLAG;
      hdr_q       <= '0;
      rem_q       <= '0;
      leaf_q      <= '0;
      lcnt_q      <= '0;
      stk_top_q   <= '0;
      next_free_q <= '0;
      walk_q      <= '0;
      bits_left_q <= '0;
      rd_pend_q   <= 1'b0;
    end else if (adv) begin
      st_q        <= st_d;
      phase_q     <= phase_d;
      hdr_q       <= hdr_d;
      rem_q       <= rem_d;
      leaf_q      <= leaf_d;
      lcnt_q      <= lcnt_d;
      stk_top_q   <= stk_top_d;
      next_free_q <= next_free_d;
      walk_q      <= walk_d;
      bits_left_q <= bits_left_d;
      rd_pend_q   <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      root_q <= root_d;
      cur_q  <= cur_d;
      byte_q <= byte_d;
    end
  end

  // Build phases only write, walk phase only reads: no same-entry overlap.
  always_ff @(posedge clk_i) begin
    if (node_we && adv) begin
      node_mem[node_wa] <= node_wd;
    end
    if (node_re && adv) begin
      node_rd_q <= node_mem[node_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we && adv) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (stk_re && adv) begin
      stk_rd_q <= stk_mem[stk_ra];
    end
  end

  hsd_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (os_ctl),
    .stat_o (os_stat),
    .out_o  (out_o)
  );

`ifndef SYNTHESIS
  a_idle_hold_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == hsd_pkg::ST_IDLE) |-> !os_stat.hold_v)
    else $error("result left in hold register at byte boundary");

  a_pend_in_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (phase_q == hsd_pkg::PH_CODE))
    else $error("node read in flight outside code walk");

  a_no_rw_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(node_we && node_re))
    else $error("node memory read and write in the same cycle");

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_top_q <= StkTopW'(ALPHABET_SIZE))
    else $error("pending stack pointer past capacity");

  a_pop_after_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == hsd_pkg::ST_POP) |-> ($past(st_q) == hsd_pkg::ST_BITS))
    else $error("stack pop wait entered from wrong state");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/hsd_out_stage.sv
// Result hold register and output register; marks the last result of an item.
`default_nettype none

module hsd_out_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire hsd_pkg::os_ctl_t ctl_i,
  output hsd_pkg::os_stat_t     stat_o,
  hsd_out_if.source             out_o
);

  logic           hold_v_q;
  hsd_pkg::emit_t hold_q;
  logic           out_v_q;
  hsd_pkg::emit_t out_q;
  logic           out_last_q;
  logic           out_free;
  logic           move;
  logic           can_take;

  // hold only drains when we know whether it is the last of its item
  assign out_free = !out_v_q || out_o.ready;
  assign can_take = !hold_v_q || out_free;
  assign move     = hold_v_q && out_free && (ctl_i.push || ctl_i.flush);

  assign stat_o.push_ok  = can_take;
  assign stat_o.flush_ok = can_take;
  assign stat_o.hold_v   = hold_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (move) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
      if (ctl_i.push && can_take) begin
        hold_v_q <= 1'b1;
      end else if (ctl_i.flush && can_take) begin
        hold_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_q      <= hold_q;
      out_last_q <= ctl_i.flush;
    end
    if (ctl_i.push && can_take) begin
      hold_q <= ctl_i.item;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.out_symbol   = out_q.symbol;
  assign out_o.repeat_res   = out_q.rep;
  assign out_o.stream_done  = out_q.done;
  assign out_o.last_of_item = out_last_q;

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the Huffman stream decoder: directed tests, then random streams.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hsd_pkg::*;

  localparam int NodeCap       = 2 * AlphabetSizeDef - 1;
  localparam int StackCap      = AlphabetSizeDef;
  localparam int RandomItems   = 350;
  localparam int DrainCycles   = 40;
  localparam int HoldOffCycles = 300;
  localparam int CycleLimit    = 600000;

  // How a directed row is checked.
  typedef enum logic [1:0] {
    ROW_PREDICT = 2'd0,   // results come from the predictor
    ROW_SILENT  = 2'd1,   // no result expected
    ROW_ONE     = 2'd2    // exactly one result, typed in below
  } row_kind_e;

  typedef struct packed {
    logic [7:0]  data;
    logic        start;
    row_kind_e   kind;
    logic [7:0]  sym;
    logic [31:0] rep;
    logic        done;
  } row_t;

  typedef struct packed {
    logic [7:0]  sym;
    logic [31:0] rep;
    logic        last;
    logic        done;
  } dec_res_t;

  logic clk_i;
  logic rst_ni;

  hsd_in_if  in_if ();
  hsd_out_if out_if ();

  huffman_stream_decoder DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  int unsigned cycle_count = 0;
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Regression FAIL");
    $finish;
  end

  int       mismatch_count = 0;
  int       bytes_sent     = 0;
  bit       no_gaps        = 1'b0;
  bit       hold_off_req   = 1'b0;
  dec_res_t symbols_due [$];
  dec_res_t step_res [$];
  dec_res_t due_res;

  // ---------------------------------------------------------------------------
  // Decoder predictor: own copy of the tree memory, stack and parse state.
  // ---------------------------------------------------------------------------
  logic [26:0] node_mem   [0:NodeCap-1];
  logic [8:0]  pend_stack [0:StackCap-1];
  logic [8:0]  stk_top;
  logic [8:0]  free_node;
  logic [1:0]  hdr_seen;
  logic [31:0] sym_left;
  logic [7:0]  leaf_acc;
  logic [3:0]  leaf_cnt;
  logic [8:0]  cur_node;
  phase_e      ph;

  function automatic void reset_predictor();
    foreach (node_mem[k]) node_mem[k] = '0;
    foreach (pend_stack[k]) pend_stack[k] = '0;
    stk_top   = '0;
    free_node = '0;
    hdr_seen  = '0;
    sym_left  = '0;
    leaf_acc  = '0;
    leaf_cnt  = '0;
    cur_node  = '0;
    ph        = PH_FLAG;
  endfunction

  function automatic void add_result(logic [7:0] sym, logic [31:0] rep, logic done);
    step_res.push_back('{sym: sym, rep: rep, last: 1'b0, done: done});
  endfunction

  // Advances the predictor by one accepted byte; results land in step_res.
  function automatic void decode_byte(logic [7:0] b, logic s);
    logic        bitv;
    logic [26:0] cur;
    logic [26:0] nxt_v;
    logic [8:0]  nxt;
    step_res.delete();
    if (s) ph = PH_FLAG;
    case (ph)
      PH_FLAG: begin
        if (s) begin
          if (b == FlagPass) begin
            ph = PH_PASS;
          end else if (b == FlagCoded) begin
            ph       = PH_COUNT;
            hdr_seen = '0;
            sym_left = '0;
          end else begin
            ph = PH_DONE;   // unknown flag: stream dropped
          end
        end
      end
      PH_PASS: add_result(b, 32'd1, 1'b0);
      PH_COUNT: begin
        sym_left = {sym_left[23:0], b};
        if (int'(hdr_seen) + 1 >= int'(CountBytes)) begin
          hdr_seen = '0;
          if (sym_left == 0) begin
            ph = PH_DONE;
          end else begin
            ph        = PH_TREE;
            stk_top   = '0;
            free_node = 9'd1;
            cur_node  = '0;
          end
        end else begin
          hdr_seen = hdr_seen + 2'd1;
        end
      end
      default: begin
        for (int i = 7; i >= 0 && ph != PH_DONE; i--) begin
          bitv = b[i];
          if (ph == PH_TREE) begin
            if (!bitv) begin
              if (int'(free_node) + 2 > NodeCap || int'(stk_top) >= StackCap) begin
                ph = PH_DONE;   // tree too big
              end else begin
                node_mem[cur_node]  = {1'b0, 8'h00, free_node, free_node + 9'd1};
                pend_stack[stk_top] = free_node + 9'd1;
                stk_top             = stk_top + 9'd1;
                cur_node            = free_node;
                free_node           = free_node + 9'd2;
              end
            end else begin
              ph       = PH_LEAF;
              leaf_acc = '0;
              leaf_cnt = '0;
            end
          end else if (ph == PH_LEAF) begin
            leaf_acc = {leaf_acc[6:0], bitv};
            leaf_cnt = leaf_cnt + 4'd1;
            if (leaf_cnt >= 4'd8) begin
              leaf_cnt           = '0;
              node_mem[cur_node] = {1'b1, leaf_acc, 18'd0};
              if (stk_top == 0) begin
                if (cur_node == 0) begin
                  // lone leaf at the root: one result covers the whole count
                  add_result(leaf_acc, sym_left, 1'b1);
                  sym_left = '0;
                  ph       = PH_DONE;
                end else begin
                  cur_node = '0;
                  ph       = PH_CODE;
                end
              end else begin
                stk_top  = stk_top - 9'd1;
                cur_node = pend_stack[stk_top];
                ph       = PH_TREE;
              end
            end
          end else if (ph == PH_CODE) begin
            cur   = node_mem[cur_node];
            nxt   = bitv ? cur[8:0] : cur[17:9];
            nxt_v = node_mem[nxt];
            if (nxt_v[26]) begin
              sym_left = sym_left - 32'd1;
              if (sym_left == 0) ph = PH_DONE;
              add_result(nxt_v[25:18], 32'd1, sym_left == 0);
              cur_node = '0;
            end else begin
              cur_node = nxt;
            end
          end
        end
      end
    endcase
    if (step_res.size() != 0) step_res[step_res.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking.
  // ---------------------------------------------------------------------------
  task automatic flag_error(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) flag_error($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (symbols_due.size() == 0) begin
        flag_error($sformatf("result with nothing due, symbol %02h", out_if.out_symbol));
      end else begin
        due_res = symbols_due.pop_front();
        compare_field("out_symbol", 32'(out_if.out_symbol), 32'(due_res.sym));
        compare_field("repeat_res", out_if.repeat_res, due_res.rep);
        compare_field("last_of_item", 32'(out_if.last_of_item), 32'(due_res.last));
        compare_field("stream_done", 32'(out_if.stream_done), 32'(due_res.done));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    int low_len;
    int high_len;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        low_len      = HoldOffCycles;
      end else begin
        low_len = pick_gap();
      end
      if (low_len > 0) begin
        out_if.ready <= 1'b0;
        repeat (low_len) @(posedge clk_i);
      end
      high_len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(20, 50);
      out_if.ready <= 1'b1;
      repeat (high_len) @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender.
  // ---------------------------------------------------------------------------
  // valid stays high after an accept so a back-to-back item needs no second
  // assignment in the same step; it drops on a gap or when draining.
  task automatic offer(input row_t row);
    int g;
    g = no_gaps ? 0 : pick_gap();
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.in_byte      <= row.data;
    in_if.stream_start <= row.start;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    bytes_sent++;
    decode_byte(row.data, row.start);
    case (row.kind)
      ROW_PREDICT: foreach (step_res[k]) symbols_due.push_back(step_res[k]);
      ROW_ONE:     symbols_due.push_back('{sym: row.sym, rep: row.rep, last: 1'b1,
                                           done: row.done});
      default: ;
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, input logic s);
    offer('{data: b, start: s, kind: ROW_PREDICT, sym: 8'h00, rep: 32'd0, done: 1'b0});
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (symbols_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Stream generator: random full binary tree, preorder bits, then codes.
  // ---------------------------------------------------------------------------
  logic         gen_is_leaf [0:NodeCap-1];
  int           gen_left    [0:NodeCap-1];
  int           gen_right   [0:NodeCap-1];
  logic [7:0]   gen_sym     [0:NodeCap-1];
  logic [255:0] gen_code    [0:NodeCap-1];
  int           gen_len     [0:NodeCap-1];
  int           leaf_list [$];
  bit           code_bits [$];

  // Grows a tree by splitting random leaves, then writes its preorder bits.
  function automatic void build_tree(int n_leaves);
    int pick;
    int victim;
    int n_nodes;
    int nd;
    int walk [$];
    leaf_list.delete();
    code_bits.delete();
    gen_is_leaf[0] = 1'b1;
    gen_len[0]     = 0;
    gen_code[0]    = '0;
    n_nodes        = 1;
    leaf_list.push_back(0);
    while (leaf_list.size() < n_leaves) begin
      pick   = $urandom_range(0, leaf_list.size() - 1);
      victim = leaf_list[pick];
      leaf_list.delete(pick);
      gen_is_leaf[victim] = 1'b0;
      gen_left[victim]    = n_nodes;
      gen_right[victim]   = n_nodes + 1;
      for (int k = 0; k < 2; k++) begin
        gen_is_leaf[n_nodes + k] = 1'b1;
        gen_len[n_nodes + k]     = gen_len[victim] + 1;
        gen_code[n_nodes + k]    = {gen_code[victim][254:0], 1'(k)};
        leaf_list.push_back(n_nodes + k);
      end
      n_nodes += 2;
    end
    foreach (leaf_list[k]) gen_sym[leaf_list[k]] = 8'($urandom);
    walk.push_back(0);
    while (walk.size() != 0) begin
      nd = walk.pop_back();
      if (gen_is_leaf[nd]) begin
        code_bits.push_back(1'b1);
        for (int j = 7; j >= 0; j--) code_bits.push_back(gen_sym[nd][j]);
      end else begin
        code_bits.push_back(1'b0);
        walk.push_back(gen_right[nd]);
        walk.push_back(gen_left[nd]);
      end
    end
  endfunction

  // Packs code_bits MSB first, random padding in the last byte.
  task automatic send_bits(input int keep_bytes);
    logic [7:0] b;
    int         sent;
    sent = 0;
    while (code_bits.size() != 0 && sent < keep_bytes) begin
      for (int j = 0; j < 8; j++)
        b = {b[6:0], ((code_bits.size() != 0) ? code_bits.pop_front() : 1'($urandom))};
      send_byte(b, 1'b0);
      sent++;
    end
  endtask

  task automatic coded_stream(input int n_leaves, input logic [31:0] count,
                              input int n_codes, input int keep_bytes, input int trail);
    int nd;
    send_byte(FlagCoded, 1'b1);
    for (int k = CountBytes - 1; k >= 0; k--) send_byte(count[8*k +: 8], 1'b0);
    build_tree(n_leaves);
    for (int c = 0; c < n_codes; c++) begin
      nd = leaf_list[$urandom_range(0, leaf_list.size() - 1)];
      for (int j = gen_len[nd] - 1; j >= 0; j--) code_bits.push_back(gen_code[nd][j]);
    end
    send_bits(keep_bytes);
    repeat (trail) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic random_stream();
    int          kind;
    int          r;
    int          n_leaves;
    int          n_codes;
    int          keep;
    logic [31:0] count;
    kind    = $urandom_range(0, 99);
    no_gaps = ($urandom_range(0, 3) == 0);
    if (kind < 10) begin
      send_byte(FlagPass, 1'b1);
      repeat ($urandom_range(1, 12)) send_byte(8'($urandom), 1'b0);
    end else if (kind < 15) begin
      send_byte(8'($urandom_range(2, 255)), 1'b1);
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0);
    end else if (kind < 19) begin
      // stray unmarked bytes land on whatever phase the last stream left
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
    end else if (kind < 24) begin
      send_byte(FlagCoded, 1'b1);
      repeat (CountBytes) send_byte(8'h00, 1'b0);
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 12) n_leaves = 1;
      else if (r < 90) n_leaves = $urandom_range(2, 8);
      else n_leaves = $urandom_range(9, 40);
      if (n_leaves == 1) begin
        if ($urandom_range(0, 1) != 0) count = $urandom;
        else count = $urandom_range(1, 20);
      end else begin
        count = $urandom_range(1, 12);
      end
      r = $urandom_range(0, 99);
      if (n_leaves == 1) n_codes = 0;
      else if (r < 70) n_codes = count;
      else if (r < 85) n_codes = count + $urandom_range(1, 3);
      else n_codes = $urandom_range(0, count);
      // now and then the stream is cut short by the next start mark
      keep = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 1 << 20;
      coded_stream(n_leaves, count, n_codes, keep, $urandom_range(0, 2));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table.
  // ---------------------------------------------------------------------------
  row_t plan [26] = '{
    // unmarked byte right after reset: ignored
    '{8'h5A, 1'b0, ROW_SILENT,  8'h00, 32'd0, 1'b0},
    // pass-through stream, byte extremes
    '{FlagPass, 1'b1, ROW_SILENT, 8'h00, 32'd0, 1'b0},
    '{8'h00, 1'b0, ROW_ONE,     8'h00, 32'd1, 1'b0},
    '{8'hFF, 1'b0, ROW_ONE,     8'hFF, 32'd1, 1'b0},
    // unknown flag drops the stream, later bytes ignored
    '{8'hC3, 1'b1, ROW_SILENT,  8'h00, 32'd0, 1'b0},
    '{8'h3C, 1'b0, ROW_SILENT,  8'h00, 32'd0, 1'b0},
    // zero symbol count: nothing at all
    '{FlagCoded, 1'b1, ROW_SILENT, 8'h00, 32'd0, 1'b0},
    '{8'h00, 1'b0, ROW_SILENT,  8'h00, 32'd0, 1'b0},
    '{8'h00, 1'b0, ROW_SILENT,  8'h00, 32'd0, 1'b0},
    '{8'h00, 1'b0, ROW_SILENT,  8'h00, 32'd0, 1'b0},
    '{8'h00, 1'b0, ROW_SILENT,  8'h00, 32'd0, 1'b0},
    '{8'hFF, 1'b0, ROW_SILENT,  8'h00, 32'd0, 1'b0},
    // single-leaf tree, symbol AB, maximum count
    '{FlagCoded, 1'b1, ROW_SILENT, 8'h00, 32'd0, 1'b0},
    '{8'hFF, 1'b0, ROW_SILENT,  8'h00, 32'd0, 1'b0},
    '{8'hFF, 1'b0, ROW_SILENT,  8'h00, 32'd0, 1'b0},
    '{8'hFF, 1'b0, ROW_SILENT,  8'h00, 32'd0, 1'b0},
    '{8'hFF, 1'b0, ROW_SILENT,  8'h00, 32'd0, 1'b0},
    '{8'hD5, 1'b0, ROW_SILENT,  8'h00, 32'd0, 1'b0},
    '{8'h80, 1'b0, ROW_ONE,     8'hAB, 32'hFFFF_FFFF, 1'b1},
    // two leaves (00, FF), count 3, codes 0 1 1 all in the last byte
    '{FlagCoded, 1'b1, ROW_SILENT, 8'h00, 32'd0, 1'b0},
    '{8'h00, 1'b0, ROW_SILENT,  8'h00, 32'd0, 1'b0},
    '{8'h00, 1'b0, ROW_SILENT,  8'h00, 32'd0, 1'b0},
    '{8'h00, 1'b0, ROW_SILENT,  8'h00, 32'd0, 1'b0},
    '{8'h03, 1'b0, ROW_SILENT,  8'h00, 32'd0, 1'b0},
    '{8'h40, 1'b0, ROW_PREDICT, 8'h00, 32'd0, 1'b0},
    '{8'h3F, 1'b0, ROW_PREDICT, 8'h00, 32'd0, 1'b0}
  };

  initial begin
    int base;
    in_if.valid        <= 1'b0;
    in_if.in_byte      <= 8'h00;
    in_if.stream_start <= 1'b0;
    rst_ni             <= 1'b0;
    reset_predictor();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[r]) offer(plan[r]);
    send_byte(8'hEC, 1'b0);   // code bits of the two-leaf stream plus padding
    wait_drained();

    // Long output hold-off while pass-through items keep coming back to back.
    no_gaps      = 1'b1;
    hold_off_req = 1'b1;
    send_byte(FlagPass, 1'b1);
    repeat (60) send_byte(8'($urandom), 1'b0);
    wait_drained();
    no_gaps = 1'b0;

    // All-zero tree bits run out of nodes; then the largest tree that fits.
    send_byte(FlagCoded, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h05, 1'b0);
    repeat (33) send_byte(8'h00, 1'b0);
    coded_stream(AlphabetSizeDef, 32'd10, 10, 1 << 20, 1);
    wait_drained();

    base = bytes_sent;
    while (bytes_sent - base < RandomItems) begin
      random_stream();
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
    wait_drained();

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
